[design/elcb_pkg.sv]
// Package with shared types, constants and widths for the emissive light CDF builder.
`default_nettype none
package elcb_pkg;
    localparam int MaxLightsDefault = 64;
    localparam int IndexBitsDefault = 20;
    localparam int OutIndexBits = 20;
    localparam int CoordBits = 32;
    localparam int TexBits = 16;
    localparam int AreaBits = 32;
    localparam int ProbBits = 16;
    localparam int WeightBits = 48;
    localparam int TotalBits = 56;
    localparam logic [47:0] WeightMax = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] LumR = 16'd13938;
    localparam logic [15:0] LumG = 16'd46868;
    localparam logic [15:0] LumB = 16'd4730;
    localparam logic [15:0] ProbOne = 16'd32768;

    typedef enum logic [2:0] {
        FUNC_VERT_A = 3'd0,
        FUNC_VERT_B = 3'd1,
        FUNC_VERT_C = 3'd2,
        FUNC_EMIT   = 3'd3,
        FUNC_FINISH = 3'd4
    } func_t;

    typedef struct packed {
        logic [2:0]  func;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0] tex_red;
        logic [15:0] tex_green;
        logic [15:0] tex_blue;
        logic        tex_present;
    } in_item_t;

    typedef struct packed {
        logic [19:0] tri_index;
        logic [31:0] tri_area;
        logic [15:0] select_pdf;
        logic [15:0] cum_prob;
        logic        last_light;
        logic        empty_set;
        logic        overflowed;
    } out_item_t;

    // Request and response between the sequencer and the divide/root unit.
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [55:0] den;
    } calc_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } calc_rsp_t;
endpackage
`default_nettype wire

[design/elcb_if.sv]
// Valid/ready channel interfaces for the input and result items.
`default_nettype none
interface elcb_in_if;
    import elcb_pkg::*;
    logic       valid;
    logic       ready;
    in_item_t   item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface elcb_out_if;
    import elcb_pkg::*;
    logic       valid;
    logic       ready;
    out_item_t  item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

[design/emissive_light_cdf_builder_top.sv]
// Top level of the emissive light CDF builder: sequencer, light store and shared unit.
//
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   func, coord_x/y/z, tex_red/green/blue, tex_present
//  out_ch    out  valid/ready   tri_index, tri_area, select_pdf, cum_prob, flags
//
// A vertex item is stored on acceptance. An emission item forms edges, cross products,
// the area by the 32-step square root in the shared unit (a saturated area skips the
// root), then texture, luminance and weight, and stores the light. A finish item
// forms each selection probability with the 64-step divider, one light at a time,
// and each result waits until it is taken.
// Reset clears all control state; the light store needs no clearing.
// The block accepts no item while it works and holds each result until taken.
`default_nettype none
module emissive_light_cdf_builder_top #(
    parameter int MAX_LIGHTS = elcb_pkg::MaxLightsDefault,
    parameter int INDEX_BITS = elcb_pkg::IndexBitsDefault
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    elcb_in_if.sink     in_ch,
    elcb_out_if.source  out_ch
);
    import elcb_pkg::*;

    localparam int AddrBits = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int RamDepth = 1 << AddrBits;
    localparam int CountBits = $clog2(MAX_LIGHTS + 1);
    localparam logic [CountBits-1:0] CountMax = CountBits'(MAX_LIGHTS);

    typedef enum logic [4:0] {
        S_IDLE, S_EDGE, S_MUL, S_CROSS, S_SQ, S_SQRT_GO, S_SQRT_WAIT,
        S_TEX, S_LUM, S_WMUL, S_STORE, S_FIN_RD, S_FIN_DIV, S_FIN_WAIT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] vtx_reg [9];
    logic [INDEX_BITS-1:0] tri_cnt_reg;
    logic [CountBits-1:0]  light_cnt_reg;
    logic [TotalBits-1:0]  total_reg;
    logic                  ovf_reg;

    logic signed [32:0] e0_reg [3];
    logic signed [32:0] e1_reg [3];
    logic signed [48:0] prod_reg [6];
    logic [2:0]         mstep_reg;
    logic [1:0]         kstep_reg;
    logic [32:0]        half_reg [3];
    logic [64:0]        sum_reg;
    logic               sat_reg;
    logic [31:0]        area_reg;
    logic signed [32:0] col_reg [3];
    logic signed [63:0] lum_reg;
    logic [79:0]        w_reg;
    logic [AddrBits-1:0] rd_reg;
    logic [16:0]        cdf_reg;
    logic               last_reg;
    in_item_t           in_hold;

    logic               out_valid_reg;
    out_item_t          out_item_reg;

    calc_req_t  creq;
    calc_rsp_t  crsp;

    logic                 ram_we;
    logic [AddrBits-1:0]  ram_addr;
    logic [47:0]          w_rd;
    logic [INDEX_BITS-1:0] idx_rd;
    logic [31:0]          area_rd;

    elcb_calc u_calc (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

    elcb_ram #(.WIDTH(WeightBits), .DEPTH(RamDepth)) u_wram
        (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(w_reg[47:0]), .rdata(w_rd));
    elcb_ram #(.WIDTH(INDEX_BITS), .DEPTH(RamDepth)) u_iram
        (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(tri_cnt_reg), .rdata(idx_rd));
    elcb_ram #(.WIDTH(AreaBits), .DEPTH(RamDepth)) u_aram
        (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(area_reg), .rdata(area_rd));

    // One signed multiplier shared by the six cross-product terms.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        mag_p;
    logic [48:0]        trunc_p;
    logic               light_ok;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (mstep_reg)
            3'd0: begin mul_a = e0_reg[1]; mul_b = e1_reg[2]; end
            3'd1: begin mul_a = e0_reg[2]; mul_b = e1_reg[1]; end
            3'd2: begin mul_a = e0_reg[2]; mul_b = e1_reg[0]; end
            3'd3: begin mul_a = e0_reg[0]; mul_b = e1_reg[2]; end
            3'd4: begin mul_a = e0_reg[0]; mul_b = e1_reg[1]; end
            3'd5: begin mul_a = e0_reg[1]; mul_b = e1_reg[0]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p   = mul_a * mul_b;
        mag_p   = mul_p[65] ? 64'(-mul_p) : mul_p[63:0];
        trunc_p = mul_p[65] ? -49'(mag_p >> 16) : 49'(mag_p >> 16);
    end

    // Texture scaling and luminance weights, one colour per cycle.
    logic signed [32:0] tex_col;
    logic signed [49:0] tex_p;
    logic [48:0]        tex_mag;
    logic [15:0]        tex_sel;
    logic [15:0]        lum_w;
    logic signed [49:0] lum_term;
    logic [32:0]        lum88;
    logic [64:0]        wprod;

    always_comb
    begin
        tex_sel = (kstep_reg == 2'd0) ? in_hold.tex_red :
                  (kstep_reg == 2'd1) ? in_hold.tex_green : in_hold.tex_blue;
        lum_w   = (kstep_reg == 2'd0) ? LumR : (kstep_reg == 2'd1) ? LumG : LumB;
        tex_col = col_reg[kstep_reg];
        tex_p   = tex_col * $signed({1'b0, tex_sel});
        tex_mag = tex_p[49] ? 49'(-tex_p) : tex_p[48:0];
        lum_term = tex_col * $signed({1'b0, lum_w});
        lum88   = lum_reg[48:16];
        wprod   = 65'(area_reg) * 65'(lum88);
        light_ok = (w_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_hold <= in_ch.item;
        end
    end

    logic signed [49:0] cross_c;
    logic [49:0]        cross_mag;
    logic [48:0]        cross_half;
    logic [65:0]        sq_val;

    always_comb
    begin
        cross_c    = 50'(prod_reg[2*kstep_reg]) - 50'(prod_reg[2*kstep_reg+1]);
        cross_mag  = cross_c[49] ? 50'(-cross_c) : 50'(cross_c);
        cross_half = cross_mag[49:1];
        sq_val     = 66'(half_reg[kstep_reg][31:0]) * 66'(half_reg[kstep_reg][31:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        creq       = '0;
        ram_we     = 1'b0;
        ram_addr   = rd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    if (in_ch.item.func == FUNC_EMIT)
                    begin
                        state_next = S_EDGE;
                    end
                    else if (in_ch.item.func == FUNC_FINISH)
                    begin
                        state_next = S_FIN_RD;
                    end
                end
            end
            S_EDGE:      state_next = S_MUL;
            S_MUL:       state_next = (mstep_reg == 3'd5) ? S_CROSS : S_MUL;
            S_CROSS:     state_next = (kstep_reg == 2'd2) ? S_SQ : S_CROSS;
            S_SQ:        state_next = (kstep_reg == 2'd2) ? S_SQRT_GO : S_SQ;
            S_SQRT_GO:
            begin
                creq.start   = !sat_reg;
                creq.is_sqrt = 1'b1;
                creq.num     = sum_reg[63:0];
                state_next   = sat_reg ? S_TEX : S_SQRT_WAIT;
            end
            S_SQRT_WAIT: state_next = crsp.done ? S_TEX : S_SQRT_WAIT;
            S_TEX:       state_next = (kstep_reg == 2'd2) ? S_LUM : S_TEX;
            S_LUM:       state_next = (kstep_reg == 2'd2) ? S_WMUL : S_LUM;
            S_WMUL:      state_next = S_STORE;
            S_STORE:
            begin
                ram_addr = light_cnt_reg[AddrBits-1:0];
                ram_we   = light_ok && (light_cnt_reg < CountMax);
                state_next = S_IDLE;
            end
            S_FIN_RD:
            begin
                state_next = (total_reg == '0 || light_cnt_reg == '0) ? S_OUT : S_FIN_DIV;
            end
            S_FIN_DIV:
            begin
                if (!out_valid_reg)
                begin
                    creq.start = 1'b1;
                    creq.num   = 64'(w_rd) << 15;
                    creq.den   = total_reg;
                    state_next = S_FIN_WAIT;
                end
            end
            S_FIN_WAIT:  state_next = crsp.done ? S_OUT : S_FIN_WAIT;
            S_OUT:
            begin
                ram_addr = rd_reg + 1'b1;
                if (!out_valid_reg)
                begin
                    state_next = last_reg ? S_IDLE : S_FIN_DIV;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < 9; i++)
            begin
                vtx_reg[i] <= '0;
            end
            tri_cnt_reg   <= '0;
            light_cnt_reg <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            mstep_reg     <= '0;
            kstep_reg     <= '0;
            rd_reg        <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    mstep_reg <= '0;
                    kstep_reg <= '0;
                    rd_reg    <= '0;
                    if (in_ch.valid && in_ch.ready)
                    begin
                        if (in_ch.item.func <= FUNC_VERT_C)
                        begin
                            vtx_reg[in_ch.item.func*3]   <= in_ch.item.coord_x;
                            vtx_reg[in_ch.item.func*3+1] <= in_ch.item.coord_y;
                            vtx_reg[in_ch.item.func*3+2] <= in_ch.item.coord_z;
                        end
                    end
                end
                S_MUL:
                begin
                    mstep_reg <= mstep_reg + 3'd1;
                end
                S_CROSS, S_SQ, S_TEX, S_LUM:
                begin
                    kstep_reg <= (kstep_reg == 2'd2) ? 2'd0 : kstep_reg + 2'd1;
                end
                S_STORE:
                begin
                    tri_cnt_reg <= tri_cnt_reg + 1'b1;
                    if (light_ok)
                    begin
                        if (light_cnt_reg < CountMax)
                        begin
                            light_cnt_reg <= light_cnt_reg + 1'b1;
                            total_reg     <= total_reg + TotalBits'(w_reg[47:0]);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                end
                S_FIN_RD:
                begin
                    last_reg <= (total_reg == '0 || light_cnt_reg == '0) ||
                                (light_cnt_reg == CountBits'(1));
                end
                S_FIN_WAIT:
                begin
                    if (crsp.done)
                    begin
                        last_reg <= (CountBits'(rd_reg) + 1'b1 == light_cnt_reg);
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        rd_reg <= rd_reg + 1'b1;
                        if (last_reg)
                        begin
                            light_cnt_reg <= '0;
                            total_reg     <= '0;
                            ovf_reg       <= 1'b0;
                            tri_cnt_reg   <= '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_EDGE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e0_reg[k] <= 33'(vtx_reg[3+k]) - 33'(vtx_reg[k]);
                    e1_reg[k] <= 33'(vtx_reg[6+k]) - 33'(vtx_reg[k]);
                end
                sum_reg <= '0;
                sat_reg <= 1'b0;
                col_reg[0] <= 33'(in_hold.coord_x);
                col_reg[1] <= 33'(in_hold.coord_y);
                col_reg[2] <= 33'(in_hold.coord_z);
                lum_reg <= '0;
            end
            S_MUL:
            begin
                prod_reg[mstep_reg] <= trunc_p;
            end
            S_CROSS:
            begin
                half_reg[kstep_reg] <= {(|cross_half[48:32]), cross_half[31:0]};
            end
            S_SQ:
            begin
                if (half_reg[kstep_reg][32])
                begin
                    sat_reg <= 1'b1;
                end
                sum_reg <= 65'(sum_reg[63:0]) + 65'(sq_val[63:0]);
                if (sum_reg[64] || (65'(sum_reg[63:0]) + 65'(sq_val[63:0])) > 65'h0_FFFF_FFFF_FFFF_FFFF)
                begin
                    sat_reg <= 1'b1;
                end
            end
            S_SQRT_GO:
            begin
                area_reg <= 32'hFFFF_FFFF;
            end
            S_SQRT_WAIT:
            begin
                if (crsp.done)
                begin
                    area_reg <= crsp.result[31:0];
                end
            end
            S_TEX:
            begin
                if (in_hold.tex_present)
                begin
                    col_reg[kstep_reg] <= tex_p[49] ? -33'(tex_mag >> 15) : 33'(tex_mag >> 15);
                end
            end
            S_LUM:
            begin
                lum_reg <= lum_reg + 64'(lum_term);
            end
            S_WMUL:
            begin
                if (area_reg == '0 || lum_reg <= 0)
                begin
                    w_reg <= '0;
                end
                else if (wprod[64:56] != '0)
                begin
                    w_reg <= 80'(WeightMax);
                end
                else
                begin
                    w_reg <= 80'(wprod[55:8]);
                end
            end
            S_FIN_RD:
            begin
                cdf_reg <= '0;
                out_item_reg <= '0;
            end
            S_FIN_WAIT:
            begin
                if (crsp.done)
                begin
                    out_item_reg.tri_index  <= OutIndexBits'(idx_rd);
                    out_item_reg.tri_area   <= area_rd;
                    out_item_reg.select_pdf <= crsp.result[15:0];
                    cdf_reg <= ((cdf_reg + crsp.result[16:0]) > 17'(ProbOne)) ?
                               17'(ProbOne) : cdf_reg + crsp.result[16:0];
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_item_reg.cum_prob   <= (last_reg && light_cnt_reg != '0 && total_reg != '0)
                                               ? ProbOne : cdf_reg[15:0];
                    out_item_reg.last_light <= last_reg;
                    out_item_reg.empty_set  <= (total_reg == '0 || light_cnt_reg == '0);
                    out_item_reg.overflowed <= ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> !out_valid_reg)
        else $error("input accepted while a result is pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        light_cnt_reg <= CountMax)
        else $error("light count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ch.item.last_light && out_ch.ready) |=> !out_valid_reg)
        else $error("result after the last light");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN_DIV && !out_valid_reg) |=> crsp.busy)
        else $error("divider did not start");
endmodule
`default_nettype wire

[design/elcb_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module elcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[design/elcb_calc.sv]
// Shared bit-serial unit: integer square root of 64 bits or restoring divide by 56 bits.
`default_nettype none
module elcb_calc (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  elcb_pkg::calc_req_t       req,
    output elcb_pkg::calc_rsp_t       rsp
);
    import elcb_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sq_reg, sq_next;
    logic [5:0]  step_reg, step_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [55:0] den_reg, den_next;
    logic [56:0] rem_reg, rem_next;

    logic [63:0] trial;
    logic [56:0] rsh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sq_next   = sq_reg;
        step_next = step_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        trial     = res_reg + bit_reg;
        rsh       = {rem_reg[55:0], x_reg[63]};
        if (!busy_reg && req.start)
        begin
            busy_next = 1'b1;
            sq_next   = req.is_sqrt;
            x_next    = req.num;
            den_next  = req.den;
            res_next  = '0;
            rem_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            step_next = 6'd0;
        end
        else if (busy_reg)
        begin
            if (sq_reg)
            begin
                if (x_reg >= trial)
                begin
                    x_next   = x_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                x_next = {x_reg[62:0], 1'b0};
                if (rsh >= {1'b0, den_reg})
                begin
                    rem_next = rsh - {1'b0, den_reg};
                    res_next = {res_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    res_next = {res_reg[62:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd63)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        step_reg <= step_next;
        x_reg    <= x_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;
endmodule
`default_nettype wire
